>>> design/twrm_pkg.sv
// Package for the three-wire register master: command codes, bus phases,
// configuration and queue entry types shared by all modules of the block.
// Depends on nothing.
package twrm_pkg;

    localparam int BYTE_BITS = 8;
    localparam int WORD_BITS = 2 * BYTE_BITS;
    localparam int BIT_CNT_W = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_SYNC  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_OUT  = 3'd1,
        PH_IN   = 3'd2,
        PH_HOLD = 3'd3,
        PH_SYNC = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        CFG_HALF_BIT = 2'd0,
        CFG_HOLD     = 2'd1,
        CFG_SYNC     = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] half_bit_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] sync_ticks;
    } t_cfg;

    // One classified tick as it waits between the front and the engine.
    typedef struct packed {
        t_cmd                 cls;
        logic [WORD_BITS-1:0] tx_word;
        logic                 sdio_in;
    } t_item;

    // Handshake from the front queue to the engine.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_chan;

    typedef struct packed {
        logic                 chip_sel_n;
        logic                 sclk_level;
        logic                 sdio_out;
        logic                 sdio_drive;
        logic                 busy_res;
        logic                 done_res;
        logic [BYTE_BITS-1:0] rd_value;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_chan;

endpackage

>>> design/twrm_front.sv
// Front end of the three-wire register master: accepts input ticks,
// classifies the command and builds the shift word, and queues them.
// Depends on twrm_pkg.
module twrm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_cmd,
    input  logic [7:0]                    i_reg_addr,
    input  logic [7:0]                    i_wr_data,
    input  logic                          i_sdio_in,
    output twrm_pkg::t_item_chan          o_item,
    input  logic                          i_take
);
    import twrm_pkg::*;

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        w_push;
    t_item       w_item;
    t_cmd        w_cls;

    assign full   = (r_count == 2'd2);
    assign w_push = push && !full;

    // A write shifts address then data; a read shifts the address only,
    // with the low byte left zero.
    always_comb begin
        w_cls          = t_cmd'(i_cmd);
        w_item.cls     = w_cls;
        w_item.sdio_in = i_sdio_in;
        w_item.tx_word = {i_reg_addr, (w_cls == CMD_WRITE) ? i_wr_data : 8'h00};
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_take) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_take};
        end
    end

    assign o_item.valid = (r_count != 2'd0);
    assign o_item.item  = r_mem[r_rptr];

endmodule

>>> design/twrm_engine.sv
// Bus engine of the three-wire register master: steps the phase machine
// once per queued tick and produces one result for each.
// Depends on twrm_pkg.
module twrm_engine (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  twrm_pkg::t_cfg          i_cfg,
    input  twrm_pkg::t_item_chan    i_item,
    output logic                    o_take,
    input  logic                    i_res_full,
    output twrm_pkg::t_result_chan  o_res
);
    import twrm_pkg::*;

    t_phase                r_phase, n_phase;
    logic                  r_is_write, n_is_write;
    logic [BIT_CNT_W-1:0]  r_bit_count, n_bit_count;
    logic [7:0]            r_delay, n_delay;
    logic [WORD_BITS-1:0]  r_tx, n_tx;
    logic [BYTE_BITS-1:0]  r_rx, n_rx;
    logic                  r_clk_high, n_clk_high;
    logic [BYTE_BITS-1:0]  r_rd_latch, n_rd_latch;
    logic                  w_done;
    logic [7:0]            w_half_m1;
    logic [7:0]            w_hold_m1;
    logic [7:0]            w_sync_m1;

    // A zero timing register behaves as one tick.
    function automatic logic [7:0] f_ticks_m1(input logic [7:0] v);
        return (v == 8'd0) ? 8'd0 : v - 8'd1;
    endfunction

    assign w_half_m1 = f_ticks_m1(i_cfg.half_bit_ticks);
    assign w_hold_m1 = f_ticks_m1(i_cfg.hold_ticks);
    assign w_sync_m1 = f_ticks_m1(i_cfg.sync_ticks);

    assign o_take = i_item.valid && !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_is_write  <= 1'b0;
            r_bit_count <= '0;
            r_delay     <= 8'd0;
            r_tx        <= '0;
            r_rx        <= '0;
            r_clk_high  <= 1'b0;
            r_rd_latch  <= '0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_is_write  <= n_is_write;
            r_bit_count <= n_bit_count;
            r_delay     <= n_delay;
            r_tx        <= n_tx;
            r_rx        <= n_rx;
            r_clk_high  <= n_clk_high;
            r_rd_latch  <= n_rd_latch;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_is_write  = r_is_write;
        n_bit_count = r_bit_count;
        n_delay     = r_delay;
        n_tx        = r_tx;
        n_rx        = r_rx;
        n_clk_high  = r_clk_high;
        n_rd_latch  = r_rd_latch;
        w_done      = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                case (i_item.item.cls)
                    CMD_READ, CMD_WRITE: begin
                        n_is_write  = (i_item.item.cls == CMD_WRITE);
                        n_tx        = i_item.item.tx_word;
                        n_bit_count = n_is_write ? BIT_CNT_W'(WORD_BITS - 1)
                                                 : BIT_CNT_W'(BYTE_BITS - 1);
                        n_phase     = PH_OUT;
                        n_clk_high  = 1'b0;
                        n_delay     = w_half_m1;
                    end
                    CMD_SYNC: begin
                        n_phase = PH_SYNC;
                        n_delay = w_sync_m1;
                    end
                    default: begin
                    end
                endcase
            end
            PH_OUT, PH_IN: begin
                if (r_delay != 8'd0) begin
                    n_delay = r_delay - 8'd1;
                end else if (!r_clk_high) begin
                    // End of the low half: raise the clock, sample in reads.
                    n_clk_high = 1'b1;
                    n_delay    = w_half_m1;
                    if (r_phase == PH_IN) begin
                        n_rx = {r_rx[BYTE_BITS-2:0], i_item.item.sdio_in};
                    end
                end else if (r_bit_count == '0) begin
                    if (r_phase == PH_OUT && !r_is_write) begin
                        n_phase     = PH_IN;
                        n_bit_count = BIT_CNT_W'(BYTE_BITS - 1);
                        n_rx        = '0;
                        n_clk_high  = 1'b0;
                        n_delay     = w_half_m1;
                    end else begin
                        if (r_phase == PH_IN) begin
                            n_rd_latch = r_rx;
                        end
                        n_phase = PH_HOLD;
                        n_delay = w_hold_m1;
                    end
                end else begin
                    n_bit_count = r_bit_count - BIT_CNT_W'(1);
                    if (r_phase == PH_OUT) begin
                        n_tx = {r_tx[WORD_BITS-2:0], 1'b0};
                    end
                    n_clk_high = 1'b0;
                    n_delay    = w_half_m1;
                end
            end
            PH_HOLD, PH_SYNC: begin
                if (r_delay != 8'd0) begin
                    n_delay = r_delay - 8'd1;
                end else begin
                    n_phase = PH_IDLE;
                    w_done  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // The result shows pin levels after this tick's update.
    always_comb begin
        o_res.valid          = o_take;
        o_res.res.chip_sel_n = (n_phase == PH_IDLE);
        o_res.res.sclk_level = n_clk_high;
        o_res.res.sdio_drive = (n_phase == PH_OUT);
        o_res.res.sdio_out   = (n_phase == PH_OUT) && n_tx[WORD_BITS-1];
        o_res.res.busy_res   = (n_phase != PH_IDLE);
        o_res.res.done_res   = w_done;
        o_res.res.rd_value   = n_rd_latch;
    end

endmodule

>>> design/twrm_res_queue.sv
// Result queue of the three-wire register master: a two-entry queue that
// parts the engine from the result reader.
// Depends on twrm_pkg.
module twrm_res_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  twrm_pkg::t_result_chan  i_res,
    output logic                    o_full,
    output logic                    empty,
    input  logic                    pop,
    output twrm_pkg::t_result       o_res
);
    import twrm_pkg::*;

    t_result     r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        w_pop;

    assign o_full = (r_count == 2'd2);
    assign empty  = (r_count == 2'd0);
    assign w_pop  = pop && !empty;
    assign o_res  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_mem[r_wptr] <= i_res.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_res.valid) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_res.valid} - {1'b0, w_pop};
        end
    end

endmodule

>>> design/three_wire_register_master.sv
// Top level of the three-wire register master: configuration registers and
// the front queue, bus engine and result queue. Depends on twrm_pkg,
// twrm_front, twrm_engine and twrm_res_queue.
//
// Each input transfer is one tick of bus time: a command (none, read, write,
// resync), the address and write data, and the level seen on the data line.
// A tick is pushed while full is low. The engine steps its phase machine
// once per tick and yields exactly one result: the chip select, clock and
// data pin levels, busy and done flags, and the last byte read.
// Results leave through a two-entry queue: the oldest is on the result ports
// while empty is low and is removed by pop.
// A transferred tick waits in the front queue, is stepped by the engine when
// the result queue has room, and its result is registered into the result
// queue, from which it shows on the result ports. Throughput is one tick per
// cycle, set by the single engine step per cycle, as long as pop keeps up.
// When the reader stalls, the result queue fills, the engine holds, and
// then the front queue fills and raises full; nothing is lost.
// The configuration channel is always ready; index 0 is half_bit_ticks,
// 1 hold_ticks, 2 sync_ticks, and index 3 is ignored. Write it only idle.
// Synchronous reset empties both queues, puts the engine in idle with the
// clock low and restores the default timing (2, 20, 1).
module three_wire_register_master (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_reg_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_sdio_in,
    output logic              empty,
    input  logic              pop,
    output logic              o_chip_sel_n,
    output logic              o_sclk_level,
    output logic              o_sdio_out,
    output logic              o_sdio_drive,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic signed [7:0] o_rd_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import twrm_pkg::*;

    t_cfg          r_cfg;
    t_item_chan    w_item;
    logic          w_take;
    logic          w_res_full;
    t_result_chan  w_res_in;
    t_result       w_res_out;

    // Timing registers are plain flops; the engine reads them every tick.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks <= 8'd2;
            r_cfg.hold_ticks     <= 8'd20;
            r_cfg.sync_ticks     <= 8'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HALF_BIT: r_cfg.half_bit_ticks <= i_cfg_data;
                CFG_HOLD:     r_cfg.hold_ticks     <= i_cfg_data;
                CFG_SYNC:     r_cfg.sync_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front classifies each tick and queues it for the engine.
    twrm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd      (i_cmd),
        .i_reg_addr (i_reg_addr),
        .i_wr_data  (i_wr_data),
        .i_sdio_in  (i_sdio_in),
        .o_item     (w_item),
        .i_take     (w_take)
    );

    // The engine takes one tick per cycle when the result queue has room.
    twrm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (w_item),
        .o_take     (w_take),
        .i_res_full (w_res_full),
        .o_res      (w_res_in)
    );

    twrm_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res_in),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_res_out)
    );

    assign o_chip_sel_n = w_res_out.chip_sel_n;
    assign o_sclk_level = w_res_out.sclk_level;
    assign o_sdio_out   = w_res_out.sdio_out;
    assign o_sdio_drive = w_res_out.sdio_drive;
    assign o_busy_res   = w_res_out.busy_res;
    assign o_done_res   = w_res_out.done_res;
    assign o_rd_value   = signed'(w_res_out.rd_value);

`ifndef ASSERT_OFF
    // The master drives the data line only while it holds chip select low.
    a_drive_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_sdio_drive |-> !o_chip_sel_n)
        else $error("data line driven with chip select high");

    // A finishing tick releases chip select and clears busy.
    a_done_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_done_res |-> o_chip_sel_n && !o_busy_res)
        else $error("done shown while still busy");

    // Busy and chip select always agree on a result.
    a_busy_matches_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_busy_res != o_chip_sel_n))
        else $error("busy and chip select disagree");

    // Reset leaves both queues empty.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");
`endif

endmodule
